@@ src/rmte_pkg.sv @@
// Shared constants, types and arithmetic helpers for the rotation matrix to Euler angle block.
package rmte_pkg;

	localparam int CORDIC_STAGES_DEF = 16;
	localparam int MAX_TABLE         = 24;
	localparam int SQ_STEPS          = 29;
	localparam int CW                = 34;
	localparam int ZW                = 28;
	localparam int AW                = 30;
	localparam int EW                = 16;
	localparam int TOL_W             = 11;
	localparam int LANES             = 5;

	localparam int LANE_X1 = 0;
	localparam int LANE_Z1 = 1;
	localparam int LANE_X2 = 2;
	localparam int LANE_Z2 = 3;
	localparam int LANE_Y  = 4;

	localparam logic signed [ZW-1:0] ANG_PI      = 28'sd52707179;
	localparam logic signed [ZW-1:0] ANG_HALF_PI = 28'sd26353589;
	localparam logic signed [AW-1:0] SAT_HI      = 30'sd32767;
	localparam logic signed [AW-1:0] SAT_LO      = -30'sd32768;
	localparam logic signed [EW-1:0] HALF_PI_OUT = 16'sd6434;

	localparam logic signed [ZW-1:0] ATAN_TAB [0:MAX_TABLE-1] = '{
		28'sd13176795, 28'sd7778716, 28'sd4110060, 28'sd2086331, 28'sd1047214, 28'sd524117,
		28'sd262123, 28'sd131069, 28'sd65536, 28'sd32768, 28'sd16384, 28'sd8192,
		28'sd4096, 28'sd2048, 28'sd1024, 28'sd512, 28'sd256, 28'sd128,
		28'sd64, 28'sd32, 28'sd16, 28'sd8, 28'sd4, 28'sd2
	};

	typedef struct packed {
		logic signed [EW-1:0] m00;
		logic signed [EW-1:0] m01;
		logic signed [EW-1:0] m02;
		logic signed [EW-1:0] m10;
		logic signed [EW-1:0] m20;
		logic signed [EW-1:0] m21;
		logic signed [EW-1:0] m22;
		logic                 lock;
	} elem_t;

	typedef struct packed {
		logic [28:0] v;
		logic [29:0] rem;
		logic [28:0] root;
	} sqrt_t;

	typedef struct packed {
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
		logic signed [ZW-1:0] z;
		logic                 zero;
	} cvec_t;

	typedef struct packed {
		logic lock;
		logic neg20;
	} flag_t;

	function automatic sqrt_t sqrt_step(sqrt_t a, int j);
		logic [57:0] r;
		logic [1:0]  pr;
		logic [31:0] t;
		logic [31:0] tr;
		sqrt_t       o;
		r  = {1'b0, a.v, 28'd0};
		pr = 2'(r >> (2 * j));
		t  = {a.rem, pr};
		tr = {2'b00, a.root[27:0], 2'b01};
		o  = a;
		if (t >= tr) begin
			o.rem  = 30'(t - tr);
			o.root = {a.root[27:0], 1'b1};
		end else begin
			o.rem  = t[29:0];
			o.root = {a.root[27:0], 1'b0};
		end
		return o;
	endfunction

	function automatic cvec_t cordic_pre(logic signed [CW-1:0] y, logic signed [CW-1:0] x);
		cvec_t o;
		o.zero = (x == '0) && (y == '0);
		o.x    = x;
		o.y    = y;
		o.z    = '0;
		if (x[CW-1]) begin
			if (!y[CW-1]) begin
				o.x = y;
				o.y = -x;
				o.z = ANG_HALF_PI;
			end else begin
				o.x = -y;
				o.y = x;
				o.z = -ANG_HALF_PI;
			end
		end
		return o;
	endfunction

	function automatic cvec_t cordic_step(cvec_t a, int i);
		logic signed [CW-1:0] xs;
		logic signed [CW-1:0] ys;
		cvec_t                o;
		xs = a.x >>> i;
		ys = a.y >>> i;
		o  = a;
		if (!a.y[CW-1]) begin
			o.x = a.x + ys;
			o.y = a.y - xs;
			o.z = a.z + ATAN_TAB[i];
		end else begin
			o.x = a.x - ys;
			o.y = a.y + xs;
			o.z = a.z - ATAN_TAB[i];
		end
		return o;
	endfunction

	function automatic logic signed [EW-1:0] to_out(logic signed [AW-1:0] a);
		logic signed [AW-1:0] t;
		t = (a + 30'sd2048) >>> 12;
		if (t > SAT_HI) begin
			t = SAT_HI;
		end else if (t < SAT_LO) begin
			t = SAT_LO;
		end
		return t[EW-1:0];
	endfunction

endpackage

@@ src/rotation_matrix_to_euler_angles.sv @@
// Rotation matrix to XYZ Euler angles: fully pipelined square root and CORDIC datapath.
//
// Input stream s_axis carries seven Q1.14 matrix elements per transfer; output
// stream m_axis carries three angles (radians * 4096) in tdata and the
// gimbal-lock and alternate-solution flags in tuser.
// gimbal_tolerance_we writes the Q1.14 gimbal tolerance; write it while idle.
// The pipeline holds one input register, 29 square-root digit stages for
// cos(y), one quadrant stage, CORDIC_STAGES rotation stages, then rounding,
// squaring and select/output.
// Throughput is one transfer per cycle while the output is not stalled: five
// CORDIC lanes run side by side, every stage holds one item.
// When m_axis_tready is low and the output holds a transfer, the whole
// pipeline holds and s_axis_tready drops; no transfer is lost or repeated.
// Reset clears all valid bits and sets the tolerance to 1.
module rotation_matrix_to_euler_angles #(
	parameter int CORDIC_STAGES = rmte_pkg::CORDIC_STAGES_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           gimbal_tolerance_we,
	input  logic [rmte_pkg::TOL_W-1:0]     gimbal_tolerance,
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	// m_0_0, m_0_1, m_0_2, m_1_0, m_2_0, m_2_1, m_2_2 (16 bits each, lowest first)
	input  logic [111:0]                   s_axis_tdata,
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	// angle_x, angle_y, angle_z (16 bits each, lowest first)
	output logic [47:0]                    m_axis_tdata,
	// gimbal_locked, alternate_chosen (lowest first)
	output logic [1:0]                     m_axis_tuser
);

	localparam int SQ  = rmte_pkg::SQ_STEPS;
	localparam int NV  = SQ + CORDIC_STAGES + 4;

	logic                       ce;
	logic [rmte_pkg::TOL_W-1:0] tol_q;
	logic                       vld_s [0:NV-1];

	rmte_pkg::elem_t  in_e;
	logic signed [16:0] m20x;
	logic [16:0]        mag20;
	logic [27:0]        mag_sq;
	rmte_pkg::sqrt_t    in_sq;

	rmte_pkg::elem_t el_s [0:SQ];
	rmte_pkg::sqrt_t sq_s [0:SQ];
	rmte_pkg::cvec_t cv_s [0:CORDIC_STAGES][0:rmte_pkg::LANES-1];
	rmte_pkg::flag_t fl_s [0:CORDIC_STAGES];

	logic signed [rmte_pkg::CW-1:0] e00, e01, e02, e10, e21, e22, s_y, c_x, gx_y;
	rmte_pkg::elem_t                el_l;

	logic signed [rmte_pkg::ZW-1:0] zf [0:rmte_pkg::LANES-1];
	logic signed [rmte_pkg::AW-1:0] y2_a;

	logic signed [rmte_pkg::EW-1:0] ax1_s, ay1_s, az1_s, ax2_s, ay2_s, az2_s;
	rmte_pkg::flag_t                fa_s;
	logic signed [rmte_pkg::EW-1:0] bx1_s, by1_s, bz1_s, bx2_s, by2_s, bz2_s;
	logic signed [31:0]             px1_s, py1_s, pz1_s, px2_s, py2_s, pz2_s;
	rmte_pkg::flag_t                fb_s;
	logic [33:0]                    n1, n2;
	logic                           alt;

	assign ce            = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = ce;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q <= rmte_pkg::TOL_W'(1);
		end else if (gimbal_tolerance_we) begin
			tol_q <= gimbal_tolerance;
		end
	end

	// input decode, gimbal test and square-root radicand
	always_comb begin
		in_e.m00 = s_axis_tdata[15:0];
		in_e.m01 = s_axis_tdata[31:16];
		in_e.m02 = s_axis_tdata[47:32];
		in_e.m10 = s_axis_tdata[63:48];
		in_e.m20 = s_axis_tdata[79:64];
		in_e.m21 = s_axis_tdata[95:80];
		in_e.m22 = s_axis_tdata[111:96];
		m20x     = 17'(in_e.m20);
		mag20    = m20x[16] ? 17'(-m20x) : 17'(m20x);
		in_e.lock = (18'(mag20) + 18'(tol_q)) >= 18'd16384;
		mag_sq   = 28'(mag20[13:0]) * 28'(mag20[13:0]);
		in_sq.rem  = '0;
		in_sq.root = '0;
		if (mag20 >= 17'd16384) begin
			in_sq.v = '0;
		end else begin
			in_sq.v = 29'h1000_0000 - 29'(mag_sq);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NV; k++) begin
				vld_s[k] <= 1'b0;
			end
			m_axis_tvalid <= 1'b0;
		end else if (ce) begin
			vld_s[0] <= s_axis_tvalid;
			for (int k = 1; k < NV; k++) begin
				vld_s[k] <= vld_s[k-1];
			end
			m_axis_tvalid <= vld_s[NV-1];
		end
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			el_s[0] <= in_e;
			sq_s[0] <= in_sq;
		end
	end

	// square root, one result bit per stage
	for (genvar k = 1; k <= SQ; k++) begin : g_sqrt
		always_ff @(posedge clk) begin
			if (ce) begin
				el_s[k] <= el_s[k-1];
				sq_s[k] <= rmte_pkg::sqrt_step(sq_s[k-1], SQ - k);
			end
		end
	end

	// widen to Q.28 and pick the atan2 arguments of each lane
	always_comb begin
		el_l = el_s[SQ];
		e00  = rmte_pkg::CW'(el_l.m00) <<< 14;
		e01  = rmte_pkg::CW'(el_l.m01) <<< 14;
		e02  = rmte_pkg::CW'(el_l.m02) <<< 14;
		e10  = rmte_pkg::CW'(el_l.m10) <<< 14;
		e21  = rmte_pkg::CW'(el_l.m21) <<< 14;
		e22  = rmte_pkg::CW'(el_l.m22) <<< 14;
		s_y  = -(rmte_pkg::CW'(el_l.m20) <<< 14);
		c_x  = rmte_pkg::CW'({1'b0, sq_s[SQ].root});
		gx_y = el_l.m20[rmte_pkg::EW-1] ? e01 : -e01;
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			cv_s[0][rmte_pkg::LANE_X1] <= el_l.lock ? rmte_pkg::cordic_pre(gx_y, e02)
			                                        : rmte_pkg::cordic_pre(e21, e22);
			cv_s[0][rmte_pkg::LANE_Z1] <= rmte_pkg::cordic_pre(e10, e00);
			cv_s[0][rmte_pkg::LANE_X2] <= rmte_pkg::cordic_pre(-e21, -e22);
			cv_s[0][rmte_pkg::LANE_Z2] <= rmte_pkg::cordic_pre(-e10, -e00);
			cv_s[0][rmte_pkg::LANE_Y]  <= rmte_pkg::cordic_pre(s_y, c_x);
			fl_s[0].lock  <= el_l.lock;
			fl_s[0].neg20 <= el_l.m20[rmte_pkg::EW-1];
		end
	end

	// CORDIC vectoring stages, five lanes in lockstep
	for (genvar i = 1; i <= CORDIC_STAGES; i++) begin : g_cordic
		always_ff @(posedge clk) begin
			if (ce) begin
				for (int l = 0; l < rmte_pkg::LANES; l++) begin
					cv_s[i][l] <= rmte_pkg::cordic_step(cv_s[i-1][l], i - 1);
				end
				fl_s[i] <= fl_s[i-1];
			end
		end
	end

	always_comb begin
		for (int l = 0; l < rmte_pkg::LANES; l++) begin
			zf[l] = cv_s[CORDIC_STAGES][l].zero ? '0 : cv_s[CORDIC_STAGES][l].z;
		end
		y2_a = rmte_pkg::AW'(rmte_pkg::ANG_PI) - rmte_pkg::AW'(zf[rmte_pkg::LANE_Y]);
	end

	// round and saturate
	always_ff @(posedge clk) begin
		if (ce) begin
			ax1_s <= rmte_pkg::to_out(rmte_pkg::AW'(zf[rmte_pkg::LANE_X1]));
			az1_s <= rmte_pkg::to_out(rmte_pkg::AW'(zf[rmte_pkg::LANE_Z1]));
			ax2_s <= rmte_pkg::to_out(rmte_pkg::AW'(zf[rmte_pkg::LANE_X2]));
			az2_s <= rmte_pkg::to_out(rmte_pkg::AW'(zf[rmte_pkg::LANE_Z2]));
			ay1_s <= rmte_pkg::to_out(rmte_pkg::AW'(zf[rmte_pkg::LANE_Y]));
			ay2_s <= rmte_pkg::to_out(y2_a);
			fa_s  <= fl_s[CORDIC_STAGES];
		end
	end

	// square the candidates
	always_ff @(posedge clk) begin
		if (ce) begin
			bx1_s <= ax1_s;
			by1_s <= ay1_s;
			bz1_s <= az1_s;
			bx2_s <= ax2_s;
			by2_s <= ay2_s;
			bz2_s <= az2_s;
			px1_s <= ax1_s * ax1_s;
			py1_s <= ay1_s * ay1_s;
			pz1_s <= az1_s * az1_s;
			px2_s <= ax2_s * ax2_s;
			py2_s <= ay2_s * ay2_s;
			pz2_s <= az2_s * az2_s;
			fb_s  <= fa_s;
		end
	end

	always_comb begin
		n1  = 34'(px1_s) + 34'(py1_s) + 34'(pz1_s);
		n2  = 34'(px2_s) + 34'(py2_s) + 34'(pz2_s);
		alt = !fb_s.lock && (n2 < n1);
	end

	// select and hold the result
	always_ff @(posedge clk) begin
		if (ce) begin
			if (fb_s.lock) begin
				m_axis_tdata[15:0]  <= bx1_s;
				m_axis_tdata[31:16] <= fb_s.neg20 ? rmte_pkg::HALF_PI_OUT
				                                  : -rmte_pkg::HALF_PI_OUT;
				m_axis_tdata[47:32] <= '0;
			end else if (alt) begin
				m_axis_tdata <= {bz2_s, by2_s, bx2_s};
			end else begin
				m_axis_tdata <= {bz1_s, by1_s, bx1_s};
			end
			m_axis_tuser <= {alt, fb_s.lock};
		end
	end

	a_lock_not_alt: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[0] |-> !m_axis_tuser[1])
		else $error("alternate solution flagged in gimbal branch");

	a_lock_z_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata[47:32] == '0)
		else $error("nonzero z angle in gimbal branch");

	a_lock_y_quarter: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[0] |->
			(m_axis_tdata[31:16] == 16'd6434) || (m_axis_tdata[31:16] == 16'hE6DE))
		else $error("gimbal y angle is not a quarter turn");

	a_stall_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
		else $error("input taken while output stalled");

endmodule

@@ tb/sv/rmte_checker.sv @@
// Checker for the rotation matrix to Euler angle block: predicts each result and compares it.
`timescale 1ns / 100ps
module rmte_checker (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         tol_we,
	input  logic [10:0]  tol,
	input  logic         s_tvalid,
	input  logic         s_tready,
	input  logic [111:0] s_tdata,
	input  logic         m_tvalid,
	input  logic         m_tready,
	input  logic [47:0]  m_tdata,
	input  logic [1:0]   m_tuser,
	output int           errors,
	output int           pending
);
	localparam longint PI_A = 52707179;
	localparam longint HPI_A = 26353589;

	typedef struct packed {
		logic [15:0] ax;
		logic [15:0] ay;
		logic [15:0] az;
		logic        lock;
		logic        alt;
	} angles_t;

	longint atan_lut [0:23] = '{
		13176795, 7778716, 4110060, 2086331, 1047214, 524117,
		262123, 131069, 65536, 32768, 16384, 8192,
		4096, 2048, 1024, 512, 256, 128, 64, 32, 16, 8, 4, 2};

	logic [10:0] tol_model;
	angles_t     angle_q [$];

	function automatic longint floor_shr(longint v, int s);
		return v >>> s;
	endfunction

	function automatic longint root_floor(longint unsigned v);
		longint unsigned res;
		longint unsigned b;
		res = 0;
		b = 64'd1 << 62;
		while (b > v) b = b >> 2;
		while (b != 0) begin
			if (v >= res + b) begin
				v = v - (res + b);
				res = (res >> 1) + b;
			end else begin
				res = res >> 1;
			end
			b = b >> 2;
		end
		return longint'(res);
	endfunction

	function automatic longint vec_angle(longint y, longint x);
		longint z;
		longint t;
		longint xs;
		longint ys;
		z = 0;
		if (x == 0 && y == 0) return 0;
		if (x < 0) begin
			if (y >= 0) begin
				t = x; x = y; y = -t; z = HPI_A;
			end else begin
				t = x; x = -y; y = t; z = -HPI_A;
			end
		end
		for (int i = 0; i < 16; i++) begin
			xs = floor_shr(x, i);
			ys = floor_shr(y, i);
			if (y >= 0) begin
				x = x + ys; y = y - xs; z = z + atan_lut[i];
			end else begin
				x = x - ys; y = y + xs; z = z - atan_lut[i];
			end
		end
		return z;
	endfunction

	function automatic longint scale_out(longint a);
		longint r;
		r = floor_shr(a + 2048, 12);
		if (r > 32767) r = 32767;
		if (r < -32768) r = -32768;
		return r;
	endfunction

	function automatic angles_t euler_of(logic [111:0] d, logic [10:0] tl);
		longint e00, e01, e02, e10, r20, e21, e22, mag, s, c, yb;
		longint x1, y1, z1, x2, y2, z2, n1, n2;
		angles_t o;
		e00 = longint'($signed(d[15:0])) * 16384;
		e01 = longint'($signed(d[31:16])) * 16384;
		e02 = longint'($signed(d[47:32])) * 16384;
		e10 = longint'($signed(d[63:48])) * 16384;
		r20 = longint'($signed(d[79:64]));
		e21 = longint'($signed(d[95:80])) * 16384;
		e22 = longint'($signed(d[111:96])) * 16384;
		mag = r20 < 0 ? -r20 : r20;
		o = '0;
		if (16384 - mag <= longint'(tl)) begin
			o.lock = 1'b1;
			if (r20 < 0) begin
				o.ay = 16'(scale_out(HPI_A));
				o.ax = 16'(scale_out(vec_angle(e01, e02)));
			end else begin
				o.ay = 16'(scale_out(-HPI_A));
				o.ax = 16'(scale_out(vec_angle(-e01, e02)));
			end
		end else begin
			s = -r20 * 16384;
			c = root_floor((64'd1 << 56) - longint'(s * s));
			yb = vec_angle(s, c);
			x1 = scale_out(vec_angle(e21, e22));
			z1 = scale_out(vec_angle(e10, e00));
			y1 = scale_out(yb);
			x2 = scale_out(vec_angle(-e21, -e22));
			z2 = scale_out(vec_angle(-e10, -e00));
			y2 = scale_out(PI_A - yb);
			n1 = x1 * x1 + y1 * y1 + z1 * z1;
			n2 = x2 * x2 + y2 * y2 + z2 * z2;
			if (n2 < n1) begin
				o.alt = 1'b1;
				o.ax = 16'(x2); o.ay = 16'(y2); o.az = 16'(z2);
			end else begin
				o.ax = 16'(x1); o.ay = 16'(y1); o.az = 16'(z1);
			end
		end
		return o;
	endfunction

	assign pending = angle_q.size();

	always @(posedge clk or negedge arst_n) begin
		angles_t want;
		angles_t got;
		if (!arst_n) begin
			tol_model <= 11'd1;
			errors    <= 0;
			angle_q.delete();
		end else begin
			if (tol_we)
				tol_model <= tol;
			if (s_tvalid && s_tready)
				angle_q.push_back(euler_of(s_tdata, tol_model));
			if (m_tvalid && m_tready) begin
				got = {m_tdata[15:0], m_tdata[31:16], m_tdata[47:32], m_tuser[0], m_tuser[1]};
				if (angle_q.size() == 0) begin
					if (errors < 10)
						$display("unexpected transfer: %h", got);
					errors <= errors + 1;
				end else begin
					want = angle_q.pop_front();
					if (want != got) begin
						if (errors < 10)
							$display("mismatch: x %0d/%0d y %0d/%0d z %0d/%0d lock %b/%b alt %b/%b",
								$signed(want.ax), $signed(got.ax), $signed(want.ay),
								$signed(got.ay), $signed(want.az), $signed(got.az),
								want.lock, got.lock, want.alt, got.alt);
						errors <= errors + 1;
					end
				end
			end
		end
	end
endmodule

@@ tb/sv/rotation_matrix_to_euler_angles_test.sv @@
// Stimulus and verdict for the rotation matrix to Euler angle block.
`timescale 1ns / 100ps
module rotation_matrix_to_euler_angles_test;
	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         tol_we = 1'b0;
	logic [10:0]  tol = '0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [111:0] s_tdata = '0;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [47:0]  m_tdata;
	logic [1:0]   m_tuser;
	int           errors;
	int           pending;
	int           cycles = 0;
	bit           calm = 1'b0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	rotation_matrix_to_euler_angles i_dut (
		.clk(clk), .arst_n(arst_n),
		.gimbal_tolerance_we(tol_we), .gimbal_tolerance(tol),
		.s_axis_tvalid(s_tvalid), .s_axis_tready(s_tready), .s_axis_tdata(s_tdata),
		.m_axis_tvalid(m_tvalid), .m_axis_tready(m_tready),
		.m_axis_tdata(m_tdata), .m_axis_tuser(m_tuser)
	);

	rmte_checker i_check (
		.clk(clk), .arst_n(arst_n), .tol_we(tol_we), .tol(tol),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.errors(errors), .pending(pending)
	);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		m_tready <= calm || ($urandom_range(99) >= 38);
		if (cycles > 200000) begin
			$display("rotation_matrix_to_euler_angles_test: errors");
			$finish;
		end
	end

	function automatic logic [15:0] pick_elem(int mode);
		int r;
		r = $urandom_range(9);
		if (mode == 0 || r < 2) return 16'($urandom);
		case (r)
			2: return 16'sd16384;
			3: return -16'sd16384;
			4: return 16'sd0;
			5: return 16'(16384 - $urandom_range(1100));
			6: return 16'(-16384 + $urandom_range(1100));
			default: return 16'($signed($urandom_range(32768)) - 16384);
		endcase
	endfunction

	task automatic send(logic [111:0] d);
		s_tvalid <= 1'b1;
		s_tdata  <= d;
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic gap();
		while (!calm && $urandom_range(99) < 38) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (60) @(posedge clk);
	endtask

	task automatic set_tol(logic [10:0] v);
		tol_we <= 1'b1;
		tol    <= v;
		@(posedge clk);
		tol_we <= 1'b0;
	endtask

	function automatic logic [111:0] pack7(int a, int b, int c, int d, int e, int f, int g);
		return {16'(g), 16'(f), 16'(e), 16'(d), 16'(c), 16'(b), 16'(a)};
	endfunction

	initial begin
		logic [111:0] d;
		logic [10:0] tols [0:4] = '{11'd0, 11'd1024, 11'd37, 11'd2047, 11'd1};
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		send(pack7(16384, 0, 0, 0, 0, 0, 16384));
		send(pack7(0, 0, 0, 0, 0, 0, 0));
		send(pack7(-16384, 0, 0, 0, 0, 0, -16384));
		send(pack7(0, 16384, 5000, 0, 16384, 0, 0));
		send(pack7(0, -7000, -5000, 0, -16384, 0, 0));
		send(pack7(0, 0, -16384, 0, 16383, 0, 0));
		send(pack7(0, 0, 0, 0, 16382, 300, 300));
		send(pack7(-16384, 0, 0, 0, 0, 0, 16384));
		send(pack7(-9000, 0, 0, 8000, 8000, -9000, -9000));
		send(pack7(0, 0, 0, 16384, 0, 16384, 0));
		send(pack7(0, 0, 0, 0, -32768, 0, 0));
		send(pack7(-32768, 32767, -32768, 32767, 32767, -32768, 32767));
		send(pack7(32767, -32768, 32767, -32768, -32767, 32767, -32768));
		send(pack7(0, 0, 0, -16384, 0, 0, -16384));
		drain();
		for (int ph = 0; ph < 5; ph++) begin
			set_tol(tols[ph]);
			calm = (ph == 2);
			for (int n = 0; n < 90; n++) begin
				for (int k = 0; k < 7; k++)
					d[16*k +: 16] = pick_elem($urandom_range(3));
				send(d);
				if (n == 45 && ph == 1) begin
					s_tvalid <= 1'b0;
					do @(posedge clk); while (pending != 0);
				end
				gap();
			end
			drain();
		end
		calm = 1'b0;
		if (errors == 0)
			$display("rotation_matrix_to_euler_angles_test: clean");
		else
			$display("rotation_matrix_to_euler_angles_test: errors");
		$finish;
	end
endmodule

@@ files.f @@
src/rmte_pkg.sv
src/rotation_matrix_to_euler_angles.sv
tb/sv/rmte_checker.sv
tb/sv/rotation_matrix_to_euler_angles_test.sv
